// ----- sv/smmcd_pkg.sv -----
package smmcd_pkg;

    // Display geometry and sample format
    localparam int COLUMNS     = 64;
    localparam int ROWS        = 32;
    localparam int SAMPLE_BITS = 16;

    // Port field widths
    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 6;
    localparam int SPC_W      = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    // Column counter must hold COLUMNS itself; keep at least INDEX_W bits
    // so the 6-bit column index is always a plain part-select.
    localparam int COL_BITS = $clog2(COLUMNS + 1);
    localparam int COL_W    = (COL_BITS > INDEX_W) ? COL_BITS : INDEX_W;

    // ROWS * (F - v) + F, with F - v in 0..2F
    localparam int NUM_W = SAMPLE_BITS + $clog2(ROWS + 1) + 2;

    // Register index, taken from paddr[CFG_ADDR_W-1:2]
    localparam logic [CFG_ADDR_W-3:0] REG_SAMPLES_PER_COLUMN = '0;

    typedef logic signed [SAMPLE_BITS-1:0] level_t;
    typedef logic [INDEX_W-1:0]            index_t;
    typedef logic [COL_W-1:0]              col_cnt_t;

    typedef struct packed {
        col_cnt_t column;
        level_t   vmin;
        level_t   vmax;
    } extremes_t;

    // row = floor((ROWS * (F - v) + F) / 2F), clamped to ROWS
    function automatic index_t to_row(level_t v);
        logic [NUM_W-1:0] full;
        logic [NUM_W-1:0] diff;
        logic [NUM_W-1:0] num;
        logic [NUM_W-1:0] row;
        full = NUM_W'(1) << (SAMPLE_BITS - 1);
        diff = full - $unsigned(NUM_W'(v));
        num  = NUM_W'(ROWS) * diff + full;
        row  = num >> SAMPLE_BITS;
        if (row > NUM_W'(ROWS))
        begin
            row = NUM_W'(ROWS);
        end
        return row[INDEX_W-1:0];
    endfunction

endpackage

// ----- sv/smmcd_if.sv -----
interface smmcd_sample_if;
    import smmcd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       batch_start;

    modport source (output valid, sample, batch_start, input ready);
    modport sink   (input valid, sample, batch_start, output ready);
endinterface

interface smmcd_column_if;
    import smmcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] column_index;
    logic [INDEX_W-1:0] top_row;
    logic [INDEX_W-1:0] bottom_row;

    modport source (output valid, column_index, top_row, bottom_row, input ready);
    modport sink   (input valid, column_index, top_row, bottom_row, output ready);
endinterface

// ----- sv/smmcd_cfg.sv -----
module smmcd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smmcd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [smmcd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [smmcd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output logic [smmcd_pkg::SPC_W-1:0]      samples_per_column
);
    import smmcd_pkg::*;

    logic [SPC_W-1:0]        spc_reg;
    logic [SPC_W-1:0]        spc_next;
    logic [CFG_ADDR_W-3:0]   reg_index;
    logic                    wr_en;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign wr_en     = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_comb
    begin
        spc_next = spc_reg;
        if (wr_en && (reg_index == REG_SAMPLES_PER_COLUMN))
        begin
            spc_next = pwdata[SPC_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spc_reg <= SPC_W'(1);
        end
        else
        begin
            spc_reg <= spc_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_index == REG_SAMPLES_PER_COLUMN)
        begin
            prdata = CFG_DATA_W'(spc_reg);
        end
    end

    assign samples_per_column = spc_reg;

endmodule

// ----- sv/smmcd_acc.sv -----
module smmcd_acc (
    input  logic                        clk,
    input  logic                        rst_n,
    smmcd_sample_if.sink                sample_ch,
    input  logic [smmcd_pkg::SPC_W-1:0] samples_per_column,
    output smmcd_pkg::extremes_t        result,
    output logic                        result_valid,
    input  logic                        result_ready
);
    import smmcd_pkg::*;

    level_t           running_min_reg,  running_min_next;
    level_t           running_max_reg,  running_max_next;
    logic [SPC_W-1:0] count_reg,        count_next;
    col_cnt_t         column_reg,       column_next;
    logic             result_valid_reg, result_valid_next;
    extremes_t        result_reg;

    logic             accept;
    level_t           s;
    level_t           base_min;
    level_t           base_max;
    logic [SPC_W-1:0] base_count;
    col_cnt_t         base_column;
    logic             batch_full;
    level_t           new_min;
    level_t           new_max;
    logic [SPC_W-1:0] count_inc;
    logic [SPC_W-1:0] spc_eff;
    logic             col_done;

    assign sample_ch.ready = !result_valid_reg || result_ready;
    assign accept          = sample_ch.valid & sample_ch.ready;

    assign s = sample_ch.sample[SAMPLE_BITS-1:0];

    // A batch start clears everything before the sample is folded in
    assign base_min    = sample_ch.batch_start ? '0 : running_min_reg;
    assign base_max    = sample_ch.batch_start ? '0 : running_max_reg;
    assign base_count  = sample_ch.batch_start ? '0 : count_reg;
    assign base_column = sample_ch.batch_start ? '0 : column_reg;

    assign batch_full = base_column >= COL_W'(COLUMNS);
    assign new_min    = (s < base_min) ? s : base_min;
    assign new_max    = (s > base_max) ? s : base_max;
    assign count_inc  = base_count + SPC_W'(1);
    assign spc_eff    = (samples_per_column == '0) ? SPC_W'(1) : samples_per_column;
    assign col_done   = !batch_full && (count_inc >= spc_eff);

    always_comb
    begin
        running_min_next = running_min_reg;
        running_max_next = running_max_reg;
        count_next       = count_reg;
        column_next      = column_reg;
        if (accept)
        begin
            priority if (batch_full)
            begin
                running_min_next = base_min;
                running_max_next = base_max;
                count_next       = base_count;
                column_next      = base_column;
            end
            else if (col_done)
            begin
                running_min_next = '0;
                running_max_next = '0;
                count_next       = '0;
                column_next      = base_column + COL_W'(1);
            end
            else
            begin
                running_min_next = new_min;
                running_max_next = new_max;
                count_next       = count_inc;
                column_next      = base_column;
            end
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && !result_ready;
        if (accept && col_done)
        begin
            result_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_min_reg  <= '0;
            running_max_reg  <= '0;
            count_reg        <= '0;
            column_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            running_min_reg  <= running_min_next;
            running_max_reg  <= running_max_next;
            count_reg        <= count_next;
            column_reg       <= column_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && col_done)
        begin
            result_reg <= '{column: base_column, vmin: new_min, vmax: new_max};
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // Extremes start at zero, so they never cross it
    a_max_not_negative: assert property (@(posedge clk) disable iff (!rst_n)
        !running_max_reg[SAMPLE_BITS-1])
        else $error("running maximum below zero");

    a_min_not_positive: assert property (@(posedge clk) disable iff (!rst_n)
        running_min_reg[SAMPLE_BITS-1] || (running_min_reg == '0))
        else $error("running minimum above zero");

    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        column_reg <= COL_W'(COLUMNS))
        else $error("column counter past COLUMNS");

    a_held_column_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |=> $stable(column_reg))
        else $error("column advanced while a result was stalled");

endmodule

// ----- sv/smmcd_quant.sv -----
module smmcd_quant (
    input  logic                 clk,
    input  logic                 rst_n,
    input  smmcd_pkg::extremes_t extremes,
    input  logic                 extremes_valid,
    output logic                 extremes_ready,
    smmcd_column_if.source       column_ch
);
    import smmcd_pkg::*;

    logic   valid_reg, valid_next;
    index_t column_reg;
    index_t top_reg;
    index_t bottom_reg;
    logic   load;

    assign extremes_ready = !valid_reg || column_ch.ready;
    assign load           = extremes_valid && extremes_ready;

    always_comb
    begin
        valid_next = valid_reg && !column_ch.ready;
        if (load)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            column_reg <= extremes.column[INDEX_W-1:0];
            top_reg    <= to_row(extremes.vmax);
            bottom_reg <= to_row(extremes.vmin);
        end
    end

    assign column_ch.valid        = valid_reg;
    assign column_ch.column_index = column_reg;
    assign column_ch.top_row      = top_reg;
    assign column_ch.bottom_row   = bottom_reg;

    // Maximum is never below minimum, so its row is never lower on screen
    a_top_above_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (top_reg <= bottom_reg))
        else $error("top row below bottom row");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !column_ch.ready) |-> !load)
        else $error("stalled result overwritten");

    a_rows_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((top_reg <= INDEX_W'(ROWS)) && (bottom_reg <= INDEX_W'(ROWS))))
        else $error("row out of range");

endmodule

// ----- sv/scope_min_max_column_decimator_core.sv -----
// A column result is registered in the extremes register at the edge that accepts the column's
// last sample, then in the row quantizer register, from which it is offered on column_ch.
// Throughput: one sample per cycle unless a stall holds it; the running min/max compare and
// counter update are combinational, and both output stages stall only on column_ch.ready.
// Reset: extremes, sample count and column counter clear to zero, samples_per_column to 1.
module scope_min_max_column_decimator_core (
    input  logic                             clk,
    input  logic                             rst_n,
    smmcd_sample_if.sink                     sample_ch,
    smmcd_column_if.source                   column_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [smmcd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [smmcd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [smmcd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready
);
    import smmcd_pkg::*;

    logic [SPC_W-1:0] samples_per_column;
    extremes_t        extremes;
    logic             extremes_valid;
    logic             extremes_ready;

    smmcd_cfg u_cfg (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .samples_per_column (samples_per_column)
    );

    smmcd_acc u_acc (
        .clk                (clk),
        .rst_n              (rst_n),
        .sample_ch          (sample_ch),
        .samples_per_column (samples_per_column),
        .result             (extremes),
        .result_valid       (extremes_valid),
        .result_ready       (extremes_ready)
    );

    smmcd_quant u_quant (
        .clk            (clk),
        .rst_n          (rst_n),
        .extremes       (extremes),
        .extremes_valid (extremes_valid),
        .extremes_ready (extremes_ready),
        .column_ch      (column_ch)
    );

endmodule
